// ===== rtl/core/bfsa_pkg.sv =====
package bfsa_pkg;

    // input word fields
    localparam int OP_W      = 2;
    localparam int REQ_W     = 32;
    localparam int ALIGN_W   = 17;
    localparam int FADDR_W   = 32;
    localparam int OP_LSB    = 0;
    localparam int REQ_LSB   = OP_LSB + OP_W;
    localparam int ALIGN_LSB = REQ_LSB + REQ_W;
    localparam int FADDR_LSB = ALIGN_LSB + ALIGN_W;
    localparam int S_DATA_W  = 88;

    // result word fields
    localparam int OUT_ADDR_W = 32;
    localparam int STATUS_W   = 3;
    localparam int STATUS_LSB = OUT_ADDR_W;
    localparam int M_DATA_W   = 40;

    // configuration
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int BASE_W     = 32;
    localparam int ISIZE_W    = 21;
    localparam int LIMIT_W    = 32;

    localparam logic [CFG_ADDR_W-1:0] CFG_HEAP_BASE    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_INITIAL_SIZE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HEAP_LIMIT   = 2'd2;

    localparam logic [BASE_W-1:0]  RST_HEAP_BASE    = 32'h0000_0000;
    localparam logic [ISIZE_W-1:0] RST_INITIAL_SIZE = 21'h01000;
    localparam logic [LIMIT_W-1:0] RST_HEAP_LIMIT   = 32'hFFFF_FFFF;

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_ALIGNED = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_ALIGN = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

endpackage

// ===== rtl/core/bfsa_mod.sv =====
// Restoring remainder, one dividend bit per cycle.
module bfsa_mod #(
    parameter int DW = 33
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [DW-1:0]                     dividend,
    input  logic [bfsa_pkg::ALIGN_W-1:0]      divisor,
    output logic                              done,
    output logic [bfsa_pkg::ALIGN_W-1:0]      rem
);
    localparam int CNTW = $clog2(DW + 1);
    localparam int RW   = bfsa_pkg::ALIGN_W + 1;

    logic [DW-1:0]   dv_reg;
    logic [RW-1:0]   rem_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            done_reg;
    logic [RW-1:0]   trial;

    assign trial = {rem_reg[RW-2:0], dv_reg[DW-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            dv_reg   <= dividend;
            rem_reg  <= '0;
            cnt_reg  <= CNTW'(DW);
            done_reg <= 1'b0;
        end else if (cnt_reg != '0) begin
            dv_reg   <= dv_reg << 1;
            rem_reg  <= (trial >= RW'(divisor)) ? trial - RW'(divisor) : trial;
            cnt_reg  <= cnt_reg - CNTW'(1);
            done_reg <= (cnt_reg == CNTW'(1));
        end else begin
            done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg[RW-2:0];
endmodule

// ===== rtl/core/best_fit_segment_allocator.sv =====
// Best-fit segment allocator with coalescing.
// Input stream s_*: one word per request (alloc, aligned alloc, free).
// Output stream m_*: exactly one result word per request, in order.
// cfg_*: heap_base / initial_size writes rebuild the segment table;
// heap_limit takes effect on the next request. Write only while idle.
// Requests are handled one at a time. An alloc walks the linked segment
// table, one table read per cycle per segment while no remainder runs,
// then reads the tail and spare stack and commits its table writes.
// Aligned alloc runs a bit-serial remainder for each fitting free
// candidate smaller than the best so far, and for the tail if none was chosen.
// Free walks until the address matches, reads both neighbors, then commits
// its writes. The segment table memory (one read, one write port) sets the rate.
// After reset, and after a rebuild write, S_INIT writes the first segment
// before s_tready rises. The result sits in an output register; a stalled
// m_tready only holds the block once the next result is ready.
module best_fit_segment_allocator #(
    parameter int MAX_SEGMENTS = 64,
    parameter int ADDR_BITS    = 32,
    parameter int GRANULE      = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // op[1:0], req_size[33:2], alignment[50:34], free_addr[82:51]
    input  logic [bfsa_pkg::S_DATA_W-1:0]       s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // block_addr[31:0], status[34:32]
    output logic [bfsa_pkg::M_DATA_W-1:0]       m_tdata,
    input  logic                                cfg_we,
    input  logic [bfsa_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [bfsa_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    localparam int AW   = $clog2(MAX_SEGMENTS);
    localparam int IW   = $clog2(MAX_SEGMENTS + 1);
    localparam int CW   = $clog2(MAX_SEGMENTS + 1);
    localparam int LW   = ADDR_BITS + 1;
    localparam int RS_W = bfsa_pkg::REQ_W + 1;
    localparam int GB   = $clog2(GRANULE);
    localparam int WW   = ((ADDR_BITS > 32) ? ADDR_BITS : 32) + 3;
    localparam logic [IW-1:0] NIL = IW'(MAX_SEGMENTS);

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_SMOD  = 4'd3;
    localparam logic [3:0] S_TEV   = 4'd4;
    localparam logic [3:0] S_PREP  = 4'd5;
    localparam logic [3:0] S_DMOD  = 4'd6;
    localparam logic [3:0] S_DEC   = 4'd7;
    localparam logic [3:0] S_FSCAN = 4'd8;
    localparam logic [3:0] S_FN    = 4'd9;
    localparam logic [3:0] S_FP    = 4'd10;
    localparam logic [3:0] S_FDEC  = 4'd11;
    localparam logic [3:0] S_WR    = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [LW-1:0]        len;
        logic                 taken;
        logic [IW-1:0]        next;
        logic [IW-1:0]        prev;
    } entry_t;

    typedef struct packed {
        logic          en;
        logic [AW-1:0] addr;
        logic          m_start;
        logic          m_len;
        logic          m_taken;
        logic          m_next;
        logic          m_prev;
        entry_t        d;
    } wrec_t;

    function automatic entry_t mk_ent(logic [WW-1:0] st, logic [WW-1:0] ln, logic tk,
                                      logic [IW-1:0] nx, logic [IW-1:0] pv);
        entry_t e;
        e.start = ADDR_BITS'(st);
        e.len   = LW'(ln);
        e.taken = tk;
        e.next  = nx;
        e.prev  = pv;
        return e;
    endfunction

    function automatic wrec_t mk_wr(logic [AW-1:0] a, logic [4:0] msk, entry_t e);
        wrec_t w;
        w.en      = 1'b1;
        w.addr    = a;
        w.m_start = msk[4];
        w.m_len   = msk[3];
        w.m_taken = msk[2];
        w.m_next  = msk[1];
        w.m_prev  = msk[0];
        w.d       = e;
        return w;
    endfunction

    // field masks: start len taken next prev
    localparam logic [4:0] M_ALL   = 5'b11111;
    localparam logic [4:0] M_TAKEN = 5'b00100;
    localparam logic [4:0] M_LT    = 5'b01100;
    localparam logic [4:0] M_LTN   = 5'b01110;
    localparam logic [4:0] M_LN    = 5'b01010;
    localparam logic [4:0] M_LTKN  = 5'b01110;
    localparam logic [4:0] M_NEXT  = 5'b00010;
    localparam logic [4:0] M_PREV  = 5'b00001;

    // ---------------- configuration ----------------
    logic [bfsa_pkg::BASE_W-1:0]  heap_base_reg;
    logic [bfsa_pkg::ISIZE_W-1:0] init_size_reg;
    logic [bfsa_pkg::LIMIT_W-1:0] heap_limit_reg;
    logic                         rebuild;

    assign rebuild = cfg_we && (cfg_addr == bfsa_pkg::CFG_HEAP_BASE ||
                                cfg_addr == bfsa_pkg::CFG_INITIAL_SIZE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_base_reg  <= bfsa_pkg::RST_HEAP_BASE;
            init_size_reg  <= bfsa_pkg::RST_INITIAL_SIZE;
            heap_limit_reg <= bfsa_pkg::RST_HEAP_LIMIT;
        end else if (cfg_we) begin
            case (cfg_addr)
                bfsa_pkg::CFG_HEAP_BASE:    heap_base_reg  <= cfg_wdata;
                bfsa_pkg::CFG_INITIAL_SIZE: init_size_reg  <= cfg_wdata[bfsa_pkg::ISIZE_W-1:0];
                bfsa_pkg::CFG_HEAP_LIMIT:   heap_limit_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- control registers ----------------
    logic [3:0]                     state_reg;
    logic [RS_W-1:0]                rsize_reg;
    logic [bfsa_pkg::ALIGN_W-1:0]   align_reg;
    logic                           align_en_reg;
    logic [bfsa_pkg::FADDR_W-1:0]   faddr_reg;
    logic [IW-1:0]                  best_idx_reg;
    logic [LW-1:0]                  best_len_reg;
    logic [ADDR_BITS-1:0]           best_start_reg;
    logic [IW-1:0]                  best_next_reg;
    entry_t                         cur_reg, tail_e_reg, n_e_reg, p_e_reg;
    logic [AW-1:0]                  cur_idx_reg;
    logic [AW-1:0]                  s1_reg, s2_reg;
    wrec_t                          wrec_reg [3];
    logic                           push_en_reg [2];
    logic [AW-1:0]                  push_val_reg [2];
    logic [1:0]                     k_reg;
    logic [ADDR_BITS-1:0]           res_addr_reg;
    logic [bfsa_pkg::STATUS_W-1:0]  res_status_reg;
    logic [AW-1:0]                  tail_reg;
    logic [CW-1:0]                  cnt_reg;
    logic [CW-1:0]                  min_reg;
    logic                           m_tvalid_reg;
    logic [bfsa_pkg::M_DATA_W-1:0]  m_tdata_reg;

    // ---------------- segment table memory ----------------
    logic [ADDR_BITS-1:0] mem_start [MAX_SEGMENTS];
    logic [LW-1:0]        mem_len   [MAX_SEGMENTS];
    logic                 mem_taken [MAX_SEGMENTS];
    logic [IW-1:0]        mem_next  [MAX_SEGMENTS];
    logic [IW-1:0]        mem_prev  [MAX_SEGMENTS];
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        q_idx;
    entry_t               q;
    wrec_t                w;
    logic                 fw;

    assign fw = w.en && (w.addr == rd_addr);

    always_ff @(posedge aclk) begin
        if (w.en) begin
            if (w.m_start) mem_start[w.addr] <= w.d.start;
            if (w.m_len)   mem_len[w.addr]   <= w.d.len;
            if (w.m_taken) mem_taken[w.addr] <= w.d.taken;
            if (w.m_next)  mem_next[w.addr]  <= w.d.next;
            if (w.m_prev)  mem_prev[w.addr]  <= w.d.prev;
        end
        q.start <= (fw && w.m_start) ? w.d.start : mem_start[rd_addr];
        q.len   <= (fw && w.m_len)   ? w.d.len   : mem_len[rd_addr];
        q.taken <= (fw && w.m_taken) ? w.d.taken : mem_taken[rd_addr];
        q.next  <= (fw && w.m_next)  ? w.d.next  : mem_next[rd_addr];
        q.prev  <= (fw && w.m_prev)  ? w.d.prev  : mem_prev[rd_addr];
        q_idx   <= rd_addr;
    end

    // ---------------- spare slot stack ----------------
    // positions below the low-water mark read back their rebuild value
    logic [AW-1:0] spare_mem [MAX_SEGMENTS];
    logic [AW-1:0] sp_rd_addr, sp_raddr_q, sp_q, sp_val;
    logic          sp_we;
    logic [AW-1:0] sp_wval;

    always_ff @(posedge aclk) begin
        if (sp_we) spare_mem[AW'(cnt_reg)] <= sp_wval;
        sp_q       <= spare_mem[sp_rd_addr];
        sp_raddr_q <= sp_rd_addr;
    end

    assign sp_val = (CW'(sp_raddr_q) < min_reg) ? AW'(MAX_SEGMENTS - 1) - sp_raddr_q : sp_q;
    assign sp_rd_addr = (state_reg == S_TEV) ? AW'(cnt_reg - CW'(2)) : AW'(cnt_reg - CW'(1));
    assign sp_we   = (state_reg == S_WR) && (k_reg != 2'd2) && push_en_reg[k_reg[0]];
    assign sp_wval = push_val_reg[k_reg[0]];

    // ---------------- remainder unit ----------------
    logic          mod_start, mod_done;
    logic [LW-1:0] mod_div;
    logic [bfsa_pkg::ALIGN_W-1:0] mod_rem;
    logic [LW-1:0] tail_end;

    assign tail_end = LW'(tail_e_reg.start) + tail_e_reg.len;

    bfsa_mod #(.DW(LW)) u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mod_start),
        .dividend (mod_div),
        .divisor  (align_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // ---------------- input decode ----------------
    logic [bfsa_pkg::OP_W-1:0]    in_op;
    logic [bfsa_pkg::REQ_W-1:0]   in_req;
    logic [bfsa_pkg::ALIGN_W-1:0] in_align;
    logic [bfsa_pkg::FADDR_W-1:0] in_faddr;
    logic [RS_W-1:0]              in_rsum;
    logic                         accept;

    assign in_op    = s_tdata[bfsa_pkg::OP_LSB +: bfsa_pkg::OP_W];
    assign in_req   = s_tdata[bfsa_pkg::REQ_LSB +: bfsa_pkg::REQ_W];
    assign in_align = s_tdata[bfsa_pkg::ALIGN_LSB +: bfsa_pkg::ALIGN_W];
    assign in_faddr = s_tdata[bfsa_pkg::FADDR_LSB +: bfsa_pkg::FADDR_W];
    assign in_rsum  = RS_W'(in_req) + RS_W'(GRANULE - 1);
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // ---------------- scan candidate ----------------
    logic cand;
    assign cand = !q.taken && (WW'(q.len) >= WW'(rsize_reg)) &&
                  (best_idx_reg == NIL || q.len < best_len_reg);

    // ---------------- read address and remainder start ----------------
    always_comb begin
        rd_addr   = tail_reg;
        mod_start = 1'b0;
        mod_div   = LW'(q.start);
        case (state_reg)
            S_IDLE:  rd_addr = '0;
            S_SCAN: begin
                rd_addr   = (q.next == NIL) ? tail_reg : q.next[AW-1:0];
                mod_start = cand && align_en_reg;
            end
            S_SMOD:  rd_addr = (cur_reg.next == NIL) ? tail_reg : cur_reg.next[AW-1:0];
            S_FSCAN: rd_addr = q.next[AW-1:0];
            S_FN:    rd_addr = cur_reg.prev[AW-1:0];
            S_PREP: begin
                mod_start = (best_idx_reg == NIL) && align_en_reg;
                mod_div   = tail_e_reg.taken ? tail_end : LW'(tail_e_reg.start);
            end
            default: ;
        endcase
    end

    // ---------------- table write port ----------------
    always_comb begin
        w = '0;
        if (state_reg == S_INIT) begin
            w = mk_wr('0, M_ALL, mk_ent(WW'(init_base), WW'(init_len), 1'b0, NIL, NIL));
        end else if (state_reg == S_WR && k_reg != 2'd3) begin
            w = wrec_reg[k_reg];
        end
    end

    // first segment: clipped so it ends within the address space
    logic [ADDR_BITS-1:0] init_base;
    logic [WW-1:0]        init_room, init_len;
    assign init_base = ADDR_BITS'(heap_base_reg);
    assign init_room = WW'({ADDR_BITS{1'b1}}) - WW'(init_base);
    assign init_len  = (init_size_reg != '0 && WW'(init_size_reg) - WW'(1) > init_room) ?
                       init_room + WW'(1) : WW'(init_size_reg);

    // ---------------- alloc commit decision ----------------
    logic          a_fail;
    logic [WW-1:0] a_addr;
    wrec_t         a_wr [3];
    logic          a_tail_en;
    logic [AW-1:0] a_tail;
    logic [1:0]    a_pops;

    always_comb begin
        logic [WW-1:0] rs, ts, tend, al, rm, pad, bnd, lim, msk, lim1, blen, bst;
        rs   = WW'(rsize_reg);
        ts   = WW'(tail_e_reg.start);
        tend = WW'(tail_end);
        al   = WW'(align_reg);
        rm   = WW'(mod_rem);
        pad  = (rm == '0) ? '0 : al - rm;
        bnd  = ts + al - rm;
        lim  = WW'(heap_limit_reg);
        msk  = WW'({ADDR_BITS{1'b1}});
        lim1 = ((lim < msk) ? lim : msk) + WW'(1);
        blen = WW'(best_len_reg);
        bst  = WW'(best_start_reg);
        a_fail    = 1'b0;
        a_addr    = '0;
        a_wr[0]   = '0;
        a_wr[1]   = '0;
        a_wr[2]   = '0;
        a_tail_en = 1'b0;
        a_tail    = s1_reg;
        a_pops    = 2'd0;
        if (best_idx_reg != NIL) begin
            a_addr = bst;
            if (blen > rs) begin
                if (cnt_reg == '0) begin
                    a_fail = 1'b1;
                end else begin
                    a_pops  = 2'd1;
                    a_wr[0] = mk_wr(s1_reg, M_ALL, mk_ent(bst + rs, blen - rs, 1'b0,
                                    best_next_reg, best_idx_reg));
                    if (best_next_reg != NIL) begin
                        a_wr[1] = mk_wr(best_next_reg[AW-1:0], M_PREV,
                                        mk_ent('0, '0, 1'b0, NIL, IW'(s1_reg)));
                    end else begin
                        a_tail_en = 1'b1;
                    end
                    a_wr[2] = mk_wr(best_idx_reg[AW-1:0], M_LTKN,
                                    mk_ent('0, rs, 1'b1, IW'(s1_reg), NIL));
                end
            end else begin
                a_wr[0] = mk_wr(best_idx_reg[AW-1:0], M_TAKEN, mk_ent('0, '0, 1'b1, NIL, NIL));
            end
        end else if (!tail_e_reg.taken && (!align_en_reg || rm == '0)) begin
            // free tail grows to the request
            a_addr = ts;
            if (ts + rs > lim1) begin
                a_fail = 1'b1;
            end else begin
                a_wr[0] = mk_wr(tail_reg, M_LT, mk_ent('0, rs, 1'b1, NIL, NIL));
            end
        end else if (!align_en_reg || (tail_e_reg.taken && pad == '0)) begin
            // append after a taken tail
            a_addr = tend;
            if (cnt_reg == '0 || tend + rs > lim1) begin
                a_fail = 1'b1;
            end else begin
                a_pops    = 2'd1;
                a_tail_en = 1'b1;
                a_wr[0]   = mk_wr(s1_reg, M_ALL, mk_ent(tend, rs, 1'b1, NIL, IW'(tail_reg)));
                a_wr[1]   = mk_wr(tail_reg, M_NEXT, mk_ent('0, '0, 1'b0, IW'(s1_reg), NIL));
            end
        end else if (tail_e_reg.taken) begin
            // pad segment, then the new one
            a_addr = tend + pad;
            if (cnt_reg < CW'(2) || tend + pad + rs > lim1) begin
                a_fail = 1'b1;
            end else begin
                a_pops    = 2'd2;
                a_tail_en = 1'b1;
                a_tail    = s2_reg;
                a_wr[0]   = mk_wr(s1_reg, M_ALL, mk_ent(tend, pad, 1'b0, IW'(s2_reg),
                                  IW'(tail_reg)));
                a_wr[1]   = mk_wr(s2_reg, M_ALL, mk_ent(tend + pad, rs, 1'b1, NIL,
                                  IW'(s1_reg)));
                a_wr[2]   = mk_wr(tail_reg, M_NEXT, mk_ent('0, '0, 1'b0, IW'(s1_reg), NIL));
            end
        end else begin
            // free unaligned tail stretched to the boundary
            a_addr = bnd;
            if (cnt_reg == '0 || bnd + rs > lim1) begin
                a_fail = 1'b1;
            end else begin
                a_pops    = 2'd1;
                a_tail_en = 1'b1;
                a_wr[0]   = mk_wr(tail_reg, M_LN, mk_ent('0, bnd - ts, 1'b0, IW'(s1_reg), NIL));
                a_wr[1]   = mk_wr(s1_reg, M_ALL, mk_ent(bnd, rs, 1'b1, NIL, IW'(tail_reg)));
            end
        end
    end

    // ---------------- free commit decision ----------------
    wrec_t         f_wr [2];
    logic          f_tail_en;
    logic [AW-1:0] f_tail;
    logic          f_push_en [2];
    logic [AW-1:0] f_push_val [2];

    always_comb begin
        logic          mn, mp;
        logic [IW-1:0] inext;
        logic [WW-1:0] ilen;
        mn    = (cur_reg.next != NIL) && !n_e_reg.taken;
        mp    = (cur_reg.prev != NIL) && !p_e_reg.taken;
        inext = mn ? n_e_reg.next : cur_reg.next;
        ilen  = WW'(cur_reg.len) + (mn ? WW'(n_e_reg.len) : '0);
        f_wr[0]       = '0;
        f_wr[1]       = '0;
        f_tail_en     = 1'b0;
        f_tail        = cur_idx_reg;
        f_push_en[0]  = 1'b0;
        f_push_en[1]  = 1'b0;
        f_push_val[0] = cur_reg.next[AW-1:0];
        f_push_val[1] = cur_idx_reg;
        if (mp) begin
            f_wr[0] = mk_wr(cur_reg.prev[AW-1:0], M_LN,
                            mk_ent('0, WW'(p_e_reg.len) + ilen, 1'b0, inext, NIL));
            if (inext != NIL) begin
                f_wr[1] = mk_wr(inext[AW-1:0], M_PREV, mk_ent('0, '0, 1'b0, NIL, cur_reg.prev));
            end else begin
                f_tail_en = 1'b1;
                f_tail    = cur_reg.prev[AW-1:0];
            end
            f_push_en[0] = 1'b1;
            if (mn) begin
                f_push_en[1] = 1'b1;
            end else begin
                f_push_val[0] = cur_idx_reg;
            end
        end else begin
            f_wr[0] = mk_wr(cur_idx_reg, M_LTN, mk_ent('0, ilen, 1'b0, inext, NIL));
            if (mn) begin
                f_push_en[0] = 1'b1;
                if (inext != NIL) begin
                    f_wr[1] = mk_wr(inext[AW-1:0], M_PREV,
                                    mk_ent('0, '0, 1'b0, NIL, IW'(cur_idx_reg)));
                end else begin
                    f_tail_en = 1'b1;
                end
            end
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_INIT;
            m_tvalid_reg <= 1'b0;
            k_reg        <= 2'd0;
            tail_reg     <= '0;
            cnt_reg      <= CW'(MAX_SEGMENTS - 1);
            min_reg      <= CW'(MAX_SEGMENTS - 1);
        end else begin
            if (m_tvalid_reg && m_tready) m_tvalid_reg <= 1'b0;
            if (sp_we) cnt_reg <= cnt_reg + CW'(1);
            case (state_reg)
                S_INIT: begin
                    tail_reg  <= '0;
                    cnt_reg   <= CW'(MAX_SEGMENTS - 1);
                    min_reg   <= CW'(MAX_SEGMENTS - 1);
                    state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (accept) begin
                        rsize_reg      <= {in_rsum[RS_W-1:GB], GB'(0)};
                        align_reg      <= in_align;
                        align_en_reg   <= (in_op == bfsa_pkg::OP_ALIGNED);
                        faddr_reg      <= in_faddr;
                        best_idx_reg   <= NIL;
                        res_addr_reg   <= '0;
                        res_status_reg <= bfsa_pkg::ST_OK;
                        if (in_op == bfsa_pkg::OP_ALLOC || in_op == bfsa_pkg::OP_ALIGNED) begin
                            if (in_req == '0) begin
                                res_status_reg <= bfsa_pkg::ST_ZERO_SIZE;
                                state_reg      <= S_OUT;
                            end else if (in_op == bfsa_pkg::OP_ALIGNED &&
                                         (in_align == '0 || in_align[GB-1:0] != '0)) begin
                                res_status_reg <= bfsa_pkg::ST_BAD_ALIGN;
                                state_reg      <= S_OUT;
                            end else begin
                                state_reg <= S_SCAN;
                            end
                        end else if (in_op == bfsa_pkg::OP_FREE) begin
                            state_reg <= S_FSCAN;
                        end else begin
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_SCAN: begin
                    if (cand && align_en_reg) begin
                        cur_reg     <= q;
                        cur_idx_reg <= q_idx;
                        state_reg   <= S_SMOD;
                    end else begin
                        if (cand) begin
                            best_idx_reg   <= IW'(q_idx);
                            best_len_reg   <= q.len;
                            best_start_reg <= q.start;
                            best_next_reg  <= q.next;
                        end
                        if (q.next == NIL) state_reg <= S_TEV;
                    end
                end
                S_SMOD: begin
                    if (mod_done) begin
                        if (mod_rem == '0) begin
                            best_idx_reg   <= IW'(cur_idx_reg);
                            best_len_reg   <= cur_reg.len;
                            best_start_reg <= cur_reg.start;
                            best_next_reg  <= cur_reg.next;
                        end
                        state_reg <= (cur_reg.next == NIL) ? S_TEV : S_SCAN;
                    end
                end
                S_TEV: begin
                    tail_e_reg <= q;
                    s1_reg     <= sp_val;
                    state_reg  <= S_PREP;
                end
                S_PREP: begin
                    s2_reg    <= sp_val;
                    state_reg <= mod_start ? S_DMOD : S_DEC;
                end
                S_DMOD: begin
                    if (mod_done) state_reg <= S_DEC;
                end
                S_DEC: begin
                    if (a_fail) begin
                        res_status_reg <= bfsa_pkg::ST_NO_SPACE;
                        state_reg      <= S_OUT;
                    end else begin
                        res_addr_reg    <= ADDR_BITS'(a_addr);
                        wrec_reg[0]     <= a_wr[0];
                        wrec_reg[1]     <= a_wr[1];
                        wrec_reg[2]     <= a_wr[2];
                        push_en_reg[0]  <= 1'b0;
                        push_en_reg[1]  <= 1'b0;
                        if (a_tail_en) tail_reg <= a_tail;
                        cnt_reg <= cnt_reg - CW'(a_pops);
                        if (cnt_reg - CW'(a_pops) < min_reg) min_reg <= cnt_reg - CW'(a_pops);
                        k_reg     <= 2'd0;
                        state_reg <= S_WR;
                    end
                end
                S_FSCAN: begin
                    if (WW'(q.start) == WW'(faddr_reg)) begin
                        cur_reg     <= q;
                        cur_idx_reg <= q_idx;
                        state_reg   <= S_FN;
                    end else if (q.next == NIL) begin
                        res_status_reg <= bfsa_pkg::ST_NOT_FOUND;
                        state_reg      <= S_OUT;
                    end
                end
                S_FN: begin
                    n_e_reg   <= q;
                    state_reg <= S_FP;
                end
                S_FP: begin
                    p_e_reg   <= q;
                    state_reg <= S_FDEC;
                end
                S_FDEC: begin
                    wrec_reg[0]     <= f_wr[0];
                    wrec_reg[1]     <= f_wr[1];
                    wrec_reg[2]     <= '0;
                    push_en_reg[0]  <= f_push_en[0];
                    push_en_reg[1]  <= f_push_en[1];
                    push_val_reg[0] <= f_push_val[0];
                    push_val_reg[1] <= f_push_val[1];
                    if (f_tail_en) tail_reg <= f_tail;
                    k_reg     <= 2'd0;
                    state_reg <= S_WR;
                end
                S_WR: begin
                    k_reg <= k_reg + 2'd1;
                    if (k_reg == 2'd2) state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= bfsa_pkg::M_DATA_W'({res_status_reg,
                                        bfsa_pkg::OUT_ADDR_W'(res_addr_reg)});
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_INIT;
            endcase
            if (rebuild) state_reg <= S_INIT;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
endmodule

// ===== rtl/core/bfsa_chk.sv =====
module bfsa_chk (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [bfsa_pkg::S_DATA_W-1:0]       s_tdata,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [bfsa_pkg::M_DATA_W-1:0]       m_tdata,
    input logic                                cfg_we,
    input logic [bfsa_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input logic [bfsa_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    logic [bfsa_pkg::STATUS_W-1:0]   st;
    logic [bfsa_pkg::OUT_ADDR_W-1:0] ad;
    assign st = m_tdata[bfsa_pkg::STATUS_LSB +: bfsa_pkg::STATUS_W];
    assign ad = m_tdata[bfsa_pkg::OUT_ADDR_W-1:0];

    a_rst_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid && !s_tready)
        else $error("busy or valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st != bfsa_pkg::ST_OK |-> ad == '0)
        else $error("failed request returned an address");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("took a second request while busy");
endmodule

bind best_fit_segment_allocator bfsa_chk u_bfsa_chk (.*);

// ===== dv/testbench.sv =====
`default_nettype none

// Self-checking bench for the best-fit segment allocator.
// Request words stream in on s_*, one result word per request comes back on m_*.
// A local model of the segment table predicts each result when its request
// word is accepted; the monitor checks results in order.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bfsa_pkg::*;

    localparam int NSEG = 64;
    localparam int NIL = NSEG;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    // worst case per request: every segment a candidate with a serial
    // remainder, plus a heavily stalled receiver; taken many times over
    localparam longint CYCLE_LIMIT = 40_000_000;
    localparam int DRAIN_CYCLES = 3000;

    typedef struct packed {
        logic [OUT_ADDR_W-1:0] addr;
        logic [STATUS_W-1:0]   status;
    } alloc_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // op, req_size, alignment, free_addr (lowest bit up)
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // block_addr, status (lowest bit up)
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    always #2 aclk = ~aclk;

    best_fit_segment_allocator u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    // ---------------- heap model ----------------
    logic [63:0] heap_base_q, init_size_q, heap_limit_q;
    logic [63:0] seg_addr[NSEG];
    logic [63:0] seg_len[NSEG];
    bit          seg_busy[NSEG];
    int          seg_nxt[NSEG];
    int          seg_prv[NSEG];
    int          spare_stack[NSEG];
    int          spare_n, head_seg, tail_seg;
    logic [31:0] live_blocks[$];   // addresses handed out and not yet freed

    function automatic void heap_rebuild();
        logic [63:0] base, room, len;
        base = heap_base_q;
        room = 64'hFFFF_FFFF - base;
        len = init_size_q;
        if (len > 0 && len - 1 > room) len = room + 1;
        seg_addr[0] = base;
        seg_len[0] = len;
        seg_busy[0] = 0;
        seg_nxt[0] = NIL;
        seg_prv[0] = NIL;
        head_seg = 0;
        tail_seg = 0;
        spare_n = 0;
        for (int i = NSEG - 1; i >= 1; i--) begin
            spare_stack[spare_n] = i;
            spare_n++;
        end
        live_blocks.delete();
    endfunction

    function automatic bit under_limit(logic [63:0] end_addr);
        return end_addr <= heap_limit_q + 1;
    endfunction

    function automatic void link_after(int p, logic [63:0] start, logic [63:0] len);
        int s, n;
        spare_n--;
        s = spare_stack[spare_n];
        n = seg_nxt[p];
        seg_nxt[s] = n;
        seg_prv[s] = p;
        if (n != NIL) seg_prv[n] = s; else tail_seg = s;
        seg_nxt[p] = s;
        seg_addr[s] = start;
        seg_len[s] = len;
        seg_busy[s] = 0;
    endfunction

    function automatic void unlink(int s);
        int p, n;
        p = seg_prv[s];
        n = seg_nxt[s];
        if (p != NIL) seg_nxt[p] = n; else head_seg = n;
        if (n != NIL) seg_prv[n] = p; else tail_seg = p;
        if (spare_n < NSEG) begin
            spare_stack[spare_n] = s;
            spare_n++;
        end
    endfunction

    function automatic int best_fit(logic [63:0] rsize, logic [63:0] align);
        int best, i, steps;
        best = NIL;
        i = head_seg;
        steps = 0;
        while (i < NSEG && steps < NSEG) begin
            if (!seg_busy[i] && seg_len[i] >= rsize &&
                (align == 0 || seg_addr[i] % align == 0) &&
                (best == NIL || seg_len[i] < seg_len[best]))
                best = i;
            i = seg_nxt[i];
            steps++;
        end
        return best;
    endfunction

    function automatic logic [STATUS_W-1:0] carve(logic [63:0] rsize, logic [63:0] align,
                                                  output logic [63:0] addr);
        int b, t;
        logic [63:0] ts, tend, pad, bnd;
        addr = 0;
        b = best_fit(rsize, align);
        t = tail_seg;
        ts = seg_addr[t];
        tend = ts + seg_len[t];
        if (b != NIL) begin
            if (seg_len[b] > rsize) begin
                if (spare_n < 1) return ST_NO_SPACE;
                link_after(b, seg_addr[b] + rsize, seg_len[b] - rsize);
                seg_len[b] = rsize;
            end
        end else if (!seg_busy[t] && (align == 0 || ts % align == 0)) begin
            if (!under_limit(ts + rsize)) return ST_NO_SPACE;
            seg_len[t] = rsize;
            b = t;
        end else if (align == 0) begin
            if (spare_n < 1 || !under_limit(tend + rsize)) return ST_NO_SPACE;
            link_after(t, tend, rsize);
            b = tail_seg;
        end else if (seg_busy[t]) begin
            pad = (align - tend % align) % align;
            if (spare_n < (pad != 0 ? 2 : 1) || !under_limit(tend + pad + rsize))
                return ST_NO_SPACE;
            if (pad != 0) link_after(t, tend, pad);
            link_after(tail_seg, tend + pad, rsize);
            b = tail_seg;
        end else begin
            // free tail off alignment: trim it to the boundary, append there
            bnd = ts + (align - ts % align);
            if (spare_n < 1 || !under_limit(bnd + rsize)) return ST_NO_SPACE;
            seg_len[t] = bnd - ts;
            link_after(t, bnd, rsize);
            b = tail_seg;
        end
        seg_busy[b] = 1;
        addr = seg_addr[b];
        return ST_OK;
    endfunction

    function automatic logic [STATUS_W-1:0] release_seg(logic [63:0] target);
        int i, steps, n, p;
        i = head_seg;
        steps = 0;
        while (i < NSEG && steps < NSEG) begin
            if (seg_addr[i] == target) begin
                n = seg_nxt[i];
                p = seg_prv[i];
                seg_busy[i] = 0;
                if (n != NIL && !seg_busy[n]) begin
                    seg_len[i] += seg_len[n];
                    unlink(n);
                end
                if (p != NIL && !seg_busy[p]) begin
                    seg_len[p] += seg_len[i];
                    unlink(i);
                end
                foreach (live_blocks[k])
                    if (live_blocks[k] == target[31:0]) begin
                        live_blocks.delete(k);
                        break;
                    end
                return ST_OK;
            end
            i = seg_nxt[i];
            steps++;
        end
        return ST_NOT_FOUND;
    endfunction

    function automatic alloc_result_t heap_apply(logic [S_DATA_W-1:0] w);
        logic [OP_W-1:0]    op;
        logic [63:0]        req, align, faddr, rsize, addr;
        logic [STATUS_W-1:0] st;
        alloc_result_t      r;
        op = w[OP_LSB +: OP_W];
        req = 64'(w[REQ_LSB +: REQ_W]);
        align = 64'(w[ALIGN_LSB +: ALIGN_W]);
        faddr = 64'(w[FADDR_LSB +: FADDR_W]);
        addr = 0;
        st = ST_OK;
        if (op == OP_ALLOC || op == OP_ALIGNED) begin
            if (req == 0) st = ST_ZERO_SIZE;
            else if (op == OP_ALIGNED && (align == 0 || align % 16 != 0)) st = ST_BAD_ALIGN;
            else begin
                rsize = ((req + 15) / 16) * 16;
                st = carve(rsize, op == OP_ALIGNED ? align : 64'd0, addr);
                if (st == ST_OK) live_blocks.push_back(addr[31:0]);
            end
        end else if (op == OP_FREE) begin
            st = release_seg(faddr);
        end
        if (st != ST_OK) addr = 0;
        r.addr = addr[31:0];
        r.status = st;
        return r;
    endfunction

    // ---------------- driver / monitor ----------------
    logic [S_DATA_W-1:0] pending_words[$];
    alloc_result_t       expected_results[$];
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    int                  mismatches = 0;
    longint              cycle_count = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            // word accepted now: predict its result against current table state
            if (s_tvalid && s_tready) expected_results.push_back(heap_apply(s_tdata));
            if (!s_tvalid || s_tready) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_words.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: addr=%h status=%0d",
                                 m_tdata[OUT_ADDR_W-1:0], m_tdata[STATUS_LSB +: STATUS_W]);
                end else begin
                    alloc_result_t e;
                    e = expected_results.pop_front();
                    if (m_tdata[OUT_ADDR_W-1:0] !== e.addr ||
                        m_tdata[STATUS_LSB +: STATUS_W] !== e.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected addr=%h status=%0d, got addr=%h status=%0d",
                                     e.addr, e.status, m_tdata[OUT_ADDR_W-1:0],
                                     m_tdata[STATUS_LSB +: STATUS_W]);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    function automatic logic [S_DATA_W-1:0] pack_req(logic [OP_W-1:0] op, logic [31:0] req,
                                                     logic [16:0] align, logic [31:0] faddr);
        logic [S_DATA_W-1:0] w;
        w = '0;
        w[OP_LSB +: OP_W] = op;
        w[REQ_LSB +: REQ_W] = req;
        w[ALIGN_LSB +: ALIGN_W] = align;
        w[FADDR_LSB +: FADDR_W] = faddr;
        return w;
    endfunction

    // start address of some linked segment, free or taken
    function automatic logic [31:0] any_seg_start();
        int i, hops;
        i = head_seg;
        hops = $urandom_range(8);
        while (hops > 0 && seg_nxt[i] != NIL) begin
            i = seg_nxt[i];
            hops--;
        end
        return seg_addr[i][31:0];
    endfunction

    function automatic logic [S_DATA_W-1:0] random_req();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return pack_req(OP_ALLOC, $urandom_range(1, 600), 17'($urandom), $urandom);
        if (r < 52)
            return pack_req(OP_ALIGNED, $urandom_range(1, 400), 17'(16 << $urandom_range(12)),
                            $urandom);
        if (r < 82 && live_blocks.size() > 0)
            return pack_req(OP_FREE, $urandom, 17'($urandom),
                            live_blocks[$urandom_range(live_blocks.size() - 1)]);
        if (r < 86)
            return pack_req(OP_FREE, $urandom, 17'($urandom), any_seg_start());
        if (r < 90)
            return pack_req(2'($urandom), $urandom, 17'($urandom), $urandom);
        if (r < 94)
            return pack_req(OP_ALLOC, $urandom, 17'($urandom), $urandom);
        if (r < 97)
            return pack_req(OP_ALIGNED, $urandom_range(1, 5000), 17'($urandom_range(0, 131071)),
                            $urandom);
        return pack_req(OP_ALLOC, $urandom_range(1, 40000), 17'($urandom), $urandom);
    endfunction

    task automatic wait_idle();
        while (pending_words.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        // register lands at this edge; rebuilding writes refresh the model
        case (idx)
            CFG_HEAP_BASE: begin
                heap_base_q = 64'(val);
                heap_rebuild();
            end
            CFG_INITIAL_SIZE: begin
                init_size_q = 64'(val[ISIZE_W-1:0]);
                heap_rebuild();
            end
            default: heap_limit_q = 64'(val);
        endcase
    endtask

    initial begin
        logic [31:0] phase_base[5] = '{32'h0, 32'h1000_0000, 32'hFFFF_F000, 32'h0,
                                       32'h0002_0010};
        logic [31:0] phase_isize[5] = '{32'd4096, 32'd16, 32'd1048576, 32'd1048576, 32'd2000};
        logic [31:0] phase_limit[5] = '{32'hFFFF_FFFF, 32'h1000_4000, 32'hFFFF_FFFF, 32'h0,
                                        32'h0040_0000};
        int generated;

        heap_base_q = 64'(RST_HEAP_BASE);
        init_size_q = 64'(RST_INITIAL_SIZE);
        heap_limit_q = 64'(RST_HEAP_LIMIT);
        heap_rebuild();
        send_idle_pct = 19;
        recv_idle_pct = 83;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes, every op, the special cases
        pending_words.push_back(pack_req(OP_ALLOC, 32'd0, 17'd0, 32'd0));          // zero size
        pending_words.push_back(pack_req(OP_ALIGNED, 32'd0, 17'd0, 32'd0));        // zero size first
        pending_words.push_back(pack_req(OP_ALIGNED, 32'd5, 17'd0, 32'd0));        // align zero
        pending_words.push_back(pack_req(OP_ALIGNED, 32'd5, 17'h1FFFF, 32'd0));    // not granule
        pending_words.push_back(pack_req(OP_UNUSED, 32'hFFFF_FFFF, 17'h1FFFF, 32'hFFFF_FFFF));
        pending_words.push_back(pack_req(OP_ALLOC, 32'd1, 17'h1FFFF, 32'd0));      // rounds up
        pending_words.push_back(pack_req(OP_ALLOC, 32'd16, 17'd0, 32'd0));
        pending_words.push_back(pack_req(OP_FREE, 32'd0, 17'd0, 32'hFFFF_FFFF));   // unknown addr
        pending_words.push_back(pack_req(OP_FREE, 32'd0, 17'd0, 32'd16));
        pending_words.push_back(pack_req(OP_FREE, 32'd0, 17'd0, 32'd16));          // already free
        pending_words.push_back(pack_req(OP_ALIGNED, 32'd100, 17'd65536, 32'd0));  // pads tail
        pending_words.push_back(pack_req(OP_ALLOC, 32'd5000, 17'd0, 32'd0));       // splits free gap
        pending_words.push_back(pack_req(OP_ALIGNED, 32'd17, 17'd16, 32'd0));
        pending_words.push_back(pack_req(OP_FREE, 32'd0, 17'd0, 32'd65536));       // last segment
        pending_words.push_back(pack_req(OP_ALLOC, 32'hFFFF_FFFF, 17'd0, 32'd0));  // over limit
        pending_words.push_back(pack_req(OP_FREE, 32'd0, 17'd0, 32'd0));
        pending_words.push_back(pack_req(OP_ALLOC, 32'hFFFF_FFF0, 17'd0, 32'd0));  // too big for tail
        pending_words.push_back(pack_req(OP_FREE, 32'd0, 17'd0, 32'd0));
        generated = pending_words.size();
        wait_idle();

        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) begin
                write_reg(CFG_HEAP_LIMIT, phase_limit[ph]);
                write_reg(CFG_HEAP_BASE, phase_base[ph]);
                write_reg(CFG_INITIAL_SIZE, phase_isize[ph]);
            end
            for (int n = 0; n < 366; n += 16) begin
                // small batches so frees target what is really taken now
                for (int k = 0; k < 16; k++) pending_words.push_back(random_req());
                generated += 16;
                if (generated > 1250) begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end else if (generated > 620) begin
                    send_idle_pct = 83;
                    recv_idle_pct = 19;
                end
                while (pending_words.size() > 0) @(posedge aclk);
            end
            wait_idle();
        end

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
